FILE: sv/dva_pkg.sv
// ----------------------------------------------------------------------------
// dva_pkg
// Shared types, constants and the control program of the drum voice
// allocator: voice-state widths, codes, control-word layout and microcode.
// ----------------------------------------------------------------------------
package dva_pkg;

	// Voice pool size and the widths that follow from it.
	localparam int VOICES = 4;
	localparam int PTR_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CNT_W  = $clog2(VOICES + 1);
	localparam int AGE_W  = ((VOICES > 1) ? $clog2(VOICES) : 0) + 1;

	// Fixed field widths.
	localparam int NOTE_W   = 4;
	localparam int SLOT_W   = 5;
	localparam int AMP_W    = 17;
	localparam int GAIN_W   = 16;
	localparam int POLE_W   = 15;
	localparam int MASK_W   = 4;
	localparam int INDEX_W  = 2;
	localparam int COUNT_W  = 3;

	localparam logic [SLOT_W-1:0] NO_NOTE  = 5'd31;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;

	// Filter pole: floor((32735232 - 600*gain + 500) / 1000).
	// The division is a multiply by ceil(2^35 / 1000), exact for numerators below 2^25.
	localparam int NUM_W    = 25;
	localparam int MUL_W    = 26;
	localparam int PROD_W   = NUM_W + MUL_W;
	localparam int RECIP_SH = 35;
	localparam logic [MUL_W-1:0] POLE_BIAS = 26'd32735732;
	localparam logic [MUL_W-1:0] POLE_MUL  = 26'd600;
	localparam logic [MUL_W-1:0] RECIP     = 26'd34359739;

	typedef logic [VOICES-1:0] vmask_t;
	typedef logic [MASK_W-1:0] omask_t;

	// Input opcode values.
	localparam logic OPC_NOTE = 1'b0;
	localparam logic OPC_TICK = 1'b1;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_RETRIG = 2'd1,
		ACT_LOAD   = 2'd2
	} action_t;

	// Datapath operation of one control word.
	typedef enum logic [2:0] {
		DP_NOP,
		DP_REAP,
		DP_RETRIG,
		DP_LOADF,
		DP_STEAL,
		DP_POLE1,
		DP_POLE2
	} dp_op_t;

	// Voice pointer operation of one control word.
	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_CLR,
		PTR_INC
	} ptr_op_t;

	// Jump condition of one control word.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_WAIT,
		C_TICK,
		C_NEG,
		C_HIT,
		C_MORE,
		C_FULL,
		C_FREE,
		C_OLD,
		C_OUT_BUSY
	} cond_t;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	// Program addresses.
	localparam step_t S_DONE   = 5'd0;
	localparam step_t S_IDLE   = 5'd1;
	localparam step_t S_DISP   = 5'd2;
	localparam step_t S_NEG    = 5'd3;
	localparam step_t S_HIT    = 5'd4;
	localparam step_t S_HITN   = 5'd5;
	localparam step_t S_FULL   = 5'd6;
	localparam step_t S_FREE   = 5'd7;
	localparam step_t S_FREEN  = 5'd8;
	localparam step_t S_OLDC   = 5'd9;
	localparam step_t S_OLD    = 5'd10;
	localparam step_t S_OLDN   = 5'd11;
	localparam step_t S_OLDZ   = 5'd12;
	localparam step_t S_STEAL  = 5'd13;
	localparam step_t S_RETRIG = 5'd14;
	localparam step_t S_LOADF  = 5'd15;
	localparam step_t S_POLE1  = 5'd16;
	localparam step_t S_POLE2  = 5'd17;
	localparam step_t S_REAP   = 5'd18;
	localparam step_t S_RDONE  = 5'd19;

	typedef struct packed {
		dp_op_t  dp_op;
		ptr_op_t ptr_op;
		cond_t   cond;
		step_t   target;
	} ctrl_t;

	// Flags the datapath reports to the sequencer.
	typedef struct packed {
		logic tick;
		logic neg;
		logic hit;
		logic more;
		logic full;
		logic free;
		logic old;
	} status_t;

	// Control store: a jump is taken when the condition holds, else the next step runs.
	function automatic ctrl_t prog_word(input step_t s);
		ctrl_t w;
		w = '{dp_op: DP_NOP, ptr_op: PTR_HOLD, cond: C_NEVER, target: S_IDLE};
		case (s)
			S_DONE:   w = '{DP_NOP,    PTR_CLR,  C_OUT_BUSY, S_DONE};
			S_IDLE:   w = '{DP_NOP,    PTR_CLR,  C_WAIT,     S_IDLE};
			S_DISP:   w = '{DP_NOP,    PTR_HOLD, C_TICK,     S_REAP};
			S_NEG:    w = '{DP_NOP,    PTR_HOLD, C_NEG,      S_DONE};
			S_HIT:    w = '{DP_NOP,    PTR_HOLD, C_HIT,      S_RETRIG};
			S_HITN:   w = '{DP_NOP,    PTR_INC,  C_MORE,     S_HIT};
			S_FULL:   w = '{DP_NOP,    PTR_CLR,  C_FULL,     S_OLD};
			S_FREE:   w = '{DP_NOP,    PTR_HOLD, C_FREE,     S_LOADF};
			S_FREEN:  w = '{DP_NOP,    PTR_INC,  C_MORE,     S_FREE};
			S_OLDC:   w = '{DP_NOP,    PTR_CLR,  C_NEVER,    S_IDLE};
			S_OLD:    w = '{DP_NOP,    PTR_HOLD, C_OLD,      S_STEAL};
			S_OLDN:   w = '{DP_NOP,    PTR_INC,  C_MORE,     S_OLD};
			S_OLDZ:   w = '{DP_NOP,    PTR_CLR,  C_NEVER,    S_IDLE};
			S_STEAL:  w = '{DP_STEAL,  PTR_HOLD, C_ALWAYS,   S_POLE1};
			S_RETRIG: w = '{DP_RETRIG, PTR_HOLD, C_ALWAYS,   S_POLE1};
			S_LOADF:  w = '{DP_LOADF,  PTR_HOLD, C_NEVER,    S_IDLE};
			S_POLE1:  w = '{DP_POLE1,  PTR_HOLD, C_NEVER,    S_IDLE};
			S_POLE2:  w = '{DP_POLE2,  PTR_HOLD, C_ALWAYS,   S_DONE};
			S_REAP:   w = '{DP_REAP,   PTR_INC,  C_MORE,     S_REAP};
			S_RDONE:  w = '{DP_NOP,    PTR_HOLD, C_ALWAYS,   S_DONE};
			default:  w = '{DP_NOP,    PTR_CLR,  C_ALWAYS,   S_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/dva_sequencer.sv
// ----------------------------------------------------------------------------
// dva_sequencer
// Step counter and control store. Each step issues one control word and
// either jumps on its condition or moves to the next address.
// ----------------------------------------------------------------------------
module dva_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             out_busy,
	input  dva_pkg::status_t status,
	output dva_pkg::ctrl_t   ctrl,
	output logic             idle,
	output logic             deliver
);

	dva_pkg::step_t step_q;
	logic           take;

	// Current control word.
	assign ctrl = dva_pkg::prog_word(step_q);

	// Condition select.
	always_comb begin
		case (ctrl.cond)
			dva_pkg::C_NEVER:    take = 1'b0;
			dva_pkg::C_ALWAYS:   take = 1'b1;
			dva_pkg::C_WAIT:     take = !start;
			dva_pkg::C_TICK:     take = status.tick;
			dva_pkg::C_NEG:      take = status.neg;
			dva_pkg::C_HIT:      take = status.hit;
			dva_pkg::C_MORE:     take = status.more;
			dva_pkg::C_FULL:     take = status.full;
			dva_pkg::C_FREE:     take = status.free;
			dva_pkg::C_OLD:      take = status.old;
			dva_pkg::C_OUT_BUSY: take = out_busy;
			default:             take = 1'b0;
		endcase
	end

	assign idle    = (step_q == dva_pkg::S_IDLE);
	assign deliver = (step_q == dva_pkg::S_DONE) && !out_busy;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dva_pkg::S_IDLE;
		end else if (take) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + dva_pkg::STEP_W'(1);
		end
	end

endmodule

FILE: sv/dva_datapath.sv
// ----------------------------------------------------------------------------
// dva_datapath
// Voice table, sounding count, voice pointer and filter-pole arithmetic,
// driven one control word per cycle by the sequencer.
// ----------------------------------------------------------------------------
module dva_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dva_pkg::ctrl_t                 ctrl,
	input  logic                           load,
	input  logic                           opcode,
	input  logic [dva_pkg::NOTE_W-1:0]     note_number,
	input  logic signed [dva_pkg::AMP_W-1:0] amplitude,
	input  logic [dva_pkg::MASK_W-1:0]     finished_mask,
	output dva_pkg::status_t               status,
	output logic [dva_pkg::INDEX_W-1:0]    voice_index,
	output dva_pkg::action_t               action,
	output logic [dva_pkg::GAIN_W-1:0]     voice_gain,
	output logic [dva_pkg::POLE_W-1:0]     filter_pole,
	output logic [dva_pkg::MASK_W-1:0]     active_mask,
	output logic [dva_pkg::COUNT_W-1:0]    voices_sounding
);

	// Word held for the duration of the program.
	logic                          opc_q;
	logic [dva_pkg::NOTE_W-1:0]    note_q;
	logic [dva_pkg::GAIN_W-1:0]    gain_q;
	logic                          neg_q;
	logic [dva_pkg::MASK_W-1:0]    fin_q;

	// Voice state.
	logic signed [dva_pkg::AGE_W-1:0] age_q [dva_pkg::VOICES];
	logic [dva_pkg::SLOT_W-1:0]       slot_q [dva_pkg::VOICES];
	logic [dva_pkg::CNT_W-1:0]        count_q;
	logic [dva_pkg::PTR_W-1:0]        ptr_q;
	dva_pkg::action_t                 action_q;
	logic [dva_pkg::PTR_W-1:0]        vsel_q;

	// Pole arithmetic.
	logic [dva_pkg::NUM_W-1:0]  num_q;
	logic [dva_pkg::POLE_W-1:0] pole_q;
	logic [dva_pkg::MUL_W-1:0]  prod600;
	logic [dva_pkg::NUM_W-1:0]  num_d;
	logic [dva_pkg::PROD_W-1:0] prod;

	logic [dva_pkg::GAIN_W-1:0]       gain_d;
	logic signed [dva_pkg::AGE_W-1:0] age_p;
	logic [dva_pkg::AGE_W-1:0]        cnt_age;
	dva_pkg::vmask_t                  fin_ext;
	dva_pkg::vmask_t                  sound_vec;
	dva_pkg::vmask_t                  gap_dec;
	logic                             reap;

	// Amplitude above one is clamped to one.
	assign gain_d = (amplitude[dva_pkg::GAIN_W-1:0] > dva_pkg::GAIN_ONE) ?
		dva_pkg::GAIN_ONE : amplitude[dva_pkg::GAIN_W-1:0];

	// Latch the word on acceptance.
	always_ff @(posedge clk) begin
		if (load) begin
			opc_q  <= opcode;
			note_q <= note_number;
			gain_q <= gain_d;
			neg_q  <= amplitude[dva_pkg::AMP_W-1];
			fin_q  <= finished_mask;
		end
	end

	// Flags of the voice under the pointer.
	always_comb begin
		age_p     = age_q[ptr_q];
		cnt_age   = dva_pkg::AGE_W'(count_q);
		fin_ext   = dva_pkg::vmask_t'({{dva_pkg::VOICES{1'b0}}, fin_q});
		for (int j = 0; j < dva_pkg::VOICES; j++) begin
			sound_vec[j] = !age_q[j][dva_pkg::AGE_W-1];
			gap_dec[j]   = (age_q[j] > age_p);
		end
		reap = !age_p[dva_pkg::AGE_W-1] && fin_ext[ptr_q];
	end

	assign status.tick = (opc_q == dva_pkg::OPC_TICK);
	assign status.neg  = neg_q;
	assign status.hit  = (slot_q[ptr_q] == {1'b0, note_q});
	assign status.more = (ptr_q != dva_pkg::PTR_W'(dva_pkg::VOICES - 1));
	assign status.full = (count_q >= dva_pkg::CNT_W'(dva_pkg::VOICES));
	assign status.free = age_p[dva_pkg::AGE_W-1];
	assign status.old  = (age_p == '0);

	// Pole: numerator in one step, reciprocal multiply in the next.
	assign prod600 = dva_pkg::MUL_W'(gain_q) * dva_pkg::POLE_MUL;
	assign num_d   = dva_pkg::NUM_W'(dva_pkg::POLE_BIAS - prod600);
	assign prod    = dva_pkg::PROD_W'(num_q) * dva_pkg::PROD_W'(dva_pkg::RECIP);

	always_ff @(posedge clk) begin
		case (ctrl.dp_op)
			dva_pkg::DP_POLE1: num_q  <= num_d;
			dva_pkg::DP_POLE2: pole_q <= prod[dva_pkg::RECIP_SH +: dva_pkg::POLE_W];
			default: ;
		endcase
	end

	// Voice table, count, pointer and per-word result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < dva_pkg::VOICES; j++) begin
				age_q[j]  <= '1;
				slot_q[j] <= dva_pkg::NO_NOTE;
			end
			count_q  <= '0;
			ptr_q    <= '0;
			action_q <= dva_pkg::ACT_NONE;
			vsel_q   <= '0;
		end else begin
			case (ctrl.ptr_op)
				dva_pkg::PTR_CLR: ptr_q <= '0;
				dva_pkg::PTR_INC: ptr_q <= ptr_q + dva_pkg::PTR_W'(1);
				default: ;
			endcase
			if (load) begin
				action_q <= dva_pkg::ACT_NONE;
				vsel_q   <= '0;
			end
			case (ctrl.dp_op)
				// Reap a finished voice and close the age gap above it.
				dva_pkg::DP_REAP: begin
					if (reap) begin
						for (int j = 0; j < dva_pkg::VOICES; j++) begin
							if (dva_pkg::PTR_W'(j) == ptr_q) begin
								age_q[j] <= '1;
							end else if (gap_dec[j]) begin
								age_q[j] <= age_q[j] - dva_pkg::AGE_W'(1);
							end
						end
						if (count_q != '0) begin
							count_q <= count_q - dva_pkg::CNT_W'(1);
						end
					end
				end
				// Retrigger: an idle holder becomes the newest voice.
				dva_pkg::DP_RETRIG: begin
					if (age_p[dva_pkg::AGE_W-1]) begin
						age_q[ptr_q] <= cnt_age;
						count_q      <= count_q + dva_pkg::CNT_W'(1);
					end
					action_q <= dva_pkg::ACT_RETRIG;
					vsel_q   <= ptr_q;
				end
				// Load a free voice as the newest.
				dva_pkg::DP_LOADF: begin
					age_q[ptr_q]  <= cnt_age;
					slot_q[ptr_q] <= {1'b0, note_q};
					count_q       <= count_q + dva_pkg::CNT_W'(1);
					action_q      <= dva_pkg::ACT_LOAD;
					vsel_q        <= ptr_q;
				end
				// Steal the voice under the pointer and close the gap above it.
				dva_pkg::DP_STEAL: begin
					for (int j = 0; j < dva_pkg::VOICES; j++) begin
						if (dva_pkg::PTR_W'(j) == ptr_q) begin
							age_q[j] <= cnt_age - dva_pkg::AGE_W'(1);
						end else if (gap_dec[j]) begin
							age_q[j] <= age_q[j] - dva_pkg::AGE_W'(1);
						end
					end
					slot_q[ptr_q] <= {1'b0, note_q};
					action_q      <= dva_pkg::ACT_LOAD;
					vsel_q        <= ptr_q;
				end
				default: ;
			endcase
		end
	end

	// Result fields; gain and pole carry meaning only for a placed note.
	assign voice_index     = dva_pkg::INDEX_W'(vsel_q);
	assign action          = action_q;
	assign voice_gain      = (action_q != dva_pkg::ACT_NONE) ? gain_q : '0;
	assign filter_pole     = (action_q != dva_pkg::ACT_NONE) ? pole_q : '0;
	assign active_mask     = dva_pkg::omask_t'({{dva_pkg::MASK_W{1'b0}}, sound_vec});
	assign voices_sounding = dva_pkg::COUNT_W'(count_q);

endmodule

FILE: sv/drum_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// drum_voice_allocator_unit
// Hands sample-player voices to drum notes by age and reaps finished voices.
// ----------------------------------------------------------------------------
// Usage: an input word (item_valid/item_stall) is either a note-on or a
// sample tick. Every accepted word yields exactly one result word
// (result_valid/result_stall). A note-on reports the voice, the action
// (retrigger or load), the clamped gain and the one-pole filter coefficient;
// a negative amplitude changes nothing and reports zeros. A tick reaps the
// voices flagged in finished_mask. Both report the sounding mask and count.
// A short microprogram visits one voice per step. A tick steps through every
// voice; a note-on is quickest for a negative amplitude and slowest when the
// oldest voice is stolen. One word is worked on at a time; item_stall is low
// only while the sequencer waits for work, so a word is taken only once the
// result of the last one is in the output register. The next word is taken
// while a result waits there; a held result only delays the following one.
// Reset clears every voice to idle with no note held and the count to zero;
// the first word is accepted right after reset.
// ----------------------------------------------------------------------------
module drum_voice_allocator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             opcode,
	input  logic [dva_pkg::NOTE_W-1:0]       note_number,
	input  logic signed [dva_pkg::AMP_W-1:0] amplitude,
	input  logic [dva_pkg::MASK_W-1:0]       finished_mask,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [dva_pkg::INDEX_W-1:0]      voice_index,
	output logic [1:0]                       action,
	output logic [dva_pkg::GAIN_W-1:0]       voice_gain,
	output logic [dva_pkg::POLE_W-1:0]       filter_pole,
	output logic [dva_pkg::MASK_W-1:0]       active_mask,
	output logic [dva_pkg::COUNT_W-1:0]      voices_sounding
);

	dva_pkg::ctrl_t   ctrl;
	dva_pkg::status_t status;
	logic             idle;
	logic             deliver;
	logic             accept;
	logic             out_busy;
	logic             result_valid_q;

	logic [dva_pkg::INDEX_W-1:0] dp_index;
	dva_pkg::action_t            dp_action;
	logic [dva_pkg::GAIN_W-1:0]  dp_gain;
	logic [dva_pkg::POLE_W-1:0]  dp_pole;
	logic [dva_pkg::MASK_W-1:0]  dp_mask;
	logic [dva_pkg::COUNT_W-1:0] dp_count;

	logic [dva_pkg::INDEX_W-1:0] index_q;
	logic [1:0]                  action_q;
	logic [dva_pkg::GAIN_W-1:0]  gain_q;
	logic [dva_pkg::POLE_W-1:0]  pole_q;
	logic [dva_pkg::MASK_W-1:0]  mask_q;
	logic [dva_pkg::COUNT_W-1:0] count_q;

	// Input handshake.
	assign item_stall = !idle;
	assign accept     = item_valid && idle;
	assign out_busy   = result_valid_q && result_stall;

	dva_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_busy (out_busy),
		.status   (status),
		.ctrl     (ctrl),
		.idle     (idle),
		.deliver  (deliver)
	);

	dva_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.load            (accept),
		.opcode          (opcode),
		.note_number     (note_number),
		.amplitude       (amplitude),
		.finished_mask   (finished_mask),
		.status          (status),
		.voice_index     (dp_index),
		.action          (dp_action),
		.voice_gain      (dp_gain),
		.filter_pole     (dp_pole),
		.active_mask     (dp_mask),
		.voices_sounding (dp_count)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (deliver) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (deliver) begin
			index_q  <= dp_index;
			action_q <= dp_action;
			gain_q   <= dp_gain;
			pole_q   <= dp_pole;
			mask_q   <= dp_mask;
			count_q  <= dp_count;
		end
	end

	assign result_valid    = result_valid_q;
	assign voice_index     = index_q;
	assign action          = action_q;
	assign voice_gain      = gain_q;
	assign filter_pole     = pole_q;
	assign active_mask     = mask_q;
	assign voices_sounding = count_q;

endmodule

FILE: verif/dva_checker.sv
// ----------------------------------------------------------------------------
// dva_checker
// Watches the word and result channels of the drum voice allocator. It keeps
// its own voice table, works out the result of every accepted word and
// compares each delivered result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module dva_checker
	import dva_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic                      item_stall,
	input  logic                      opcode,
	input  logic [NOTE_W-1:0]         note_number,
	input  logic signed [AMP_W-1:0]   amplitude,
	input  logic [MASK_W-1:0]         finished_mask,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  logic [INDEX_W-1:0]        voice_index,
	input  logic [1:0]                action,
	input  logic [GAIN_W-1:0]         voice_gain,
	input  logic [POLE_W-1:0]         filter_pole,
	input  logic [MASK_W-1:0]         active_mask,
	input  logic [COUNT_W-1:0]        voices_sounding,
	output int                        fail_count,
	output int                        words_pending,
	output int                        loads_seen,
	output int                        steals_seen,
	output int                        retrigs_seen,
	output int                        ignored_seen,
	output int                        ticks_seen,
	output int                        reaps_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [INDEX_W-1:0] voice;
		action_t            act;
		logic [GAIN_W-1:0]  gain;
		logic [POLE_W-1:0]  pole;
		logic [MASK_W-1:0]  mask;
		logic [COUNT_W-1:0] count;
	} voice_result_t;

	// Mirror of the voice table: held note and age rank (0 oldest, -1 idle).
	logic [SLOT_W-1:0] slot_note [VOICES];
	int                slot_rank [VOICES];
	int                sounding;
	int                results_seen;

	voice_result_t     expected_results [$];

	// One line per mismatch, and the count goes up.
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at result %0d: %s got %0d, expected %0d",
			results_seen, what, got, want);
		fail_count++;
	endtask

	// Every voice younger than the freed rank moves one rank down.
	function automatic void close_rank_gap(input int freed);
		for (int j = 0; j < VOICES; j++) begin
			if (slot_rank[j] > freed)
				slot_rank[j]--;
		end
	endfunction

	// Take the voice of rank zero, or voice 0 if none has that rank.
	function automatic int steal_oldest_voice();
		int v;
		v = 0;
		for (int j = VOICES - 1; j >= 0; j--) begin
			if (slot_rank[j] == 0)
				v = j;
		end
		close_rank_gap(slot_rank[v]);
		steals_seen++;
		return v;
	endfunction

	// Apply one word to the voice table and work out its result word.
	task automatic predict_word(input logic op, input logic [NOTE_W-1:0] nt,
			input logic [AMP_W-1:0] amp, input logic [MASK_W-1:0] fin,
			output voice_result_t r);
		int               v;
		logic [GAIN_W-1:0] gain;
		r = '0;
		r.act = ACT_NONE;
		if (op == OPC_TICK) begin
			ticks_seen++;
			for (int k = 0; k < VOICES && k < MASK_W; k++) begin
				if (slot_rank[k] >= 0 && fin[k]) begin
					close_rank_gap(slot_rank[k]);
					slot_rank[k] = -1;
					if (sounding > 0)
						sounding--;
					reaps_seen++;
				end
			end
		end else if (amp[AMP_W-1]) begin
			// A negative amplitude leaves everything alone.
			ignored_seen++;
		end else begin
			gain = (amp > AMP_W'(GAIN_ONE)) ? GAIN_ONE : amp[GAIN_W-1:0];
			v = -1;
			for (int k = 0; k < VOICES; k++) begin
				if (v < 0 && slot_note[k] == {1'b0, nt})
					v = k;
			end
			if (v >= 0) begin
				// Retrigger: a sounding voice keeps its rank, an idle one
				// becomes the newest.
				if (slot_rank[v] < 0) begin
					slot_rank[v] = sounding;
					sounding++;
				end
				r.act = ACT_RETRIG;
				retrigs_seen++;
			end else begin
				if (sounding < VOICES) begin
					for (int k = 0; k < VOICES; k++) begin
						if (v < 0 && slot_rank[k] < 0)
							v = k;
					end
					if (v >= 0)
						sounding++;
					else
						v = steal_oldest_voice();
				end else begin
					v = steal_oldest_voice();
				end
				slot_rank[v] = sounding - 1;
				slot_note[v] = {1'b0, nt};
				r.act = ACT_LOAD;
				loads_seen++;
			end
			r.voice = INDEX_W'(v);
			r.gain = gain;
			r.pole = POLE_W'((32735732 - 600 * int'(gain)) / 1000);
		end
		for (int k = 0; k < VOICES && k < MASK_W; k++)
			r.mask[k] = (slot_rank[k] >= 0);
		r.count = COUNT_W'(sounding);
	endtask

	// Results are checked before the word of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		voice_result_t want;
		if (!arst_n) begin
			for (int j = 0; j < VOICES; j++) begin
				slot_note[j] = NO_NOTE;
				slot_rank[j] = -1;
			end
			sounding = 0;
			expected_results.delete();
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result word with no word outstanding, active_mask",
						active_mask, 0);
				end else begin
					want = expected_results.pop_front();
					if (voice_index !== want.voice)
						report_mismatch("voice_index", voice_index, want.voice);
					if (action !== want.act)
						report_mismatch("action", action, want.act);
					if (voice_gain !== want.gain)
						report_mismatch("voice_gain", voice_gain, want.gain);
					if (filter_pole !== want.pole)
						report_mismatch("filter_pole", filter_pole, want.pole);
					if (active_mask !== want.mask)
						report_mismatch("active_mask", active_mask, want.mask);
					if (voices_sounding !== want.count)
						report_mismatch("voices_sounding", voices_sounding, want.count);
				end
			end
			if (item_valid && !item_stall) begin
				predict_word(opcode, note_number, amplitude, finished_mask, want);
				expected_results.push_back(want);
			end
		end
		words_pending = expected_results.size();
	end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the drum voice allocator with a directed opening and a long run of
// random note-ons and sample ticks under random idling on both channels; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top
	import dva_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS   = 1333;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 40;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	logic                opcode;
	logic [NOTE_W-1:0]   note_number;
	logic signed [AMP_W-1:0] amplitude;
	logic [MASK_W-1:0]   finished_mask;
	logic                result_valid;
	logic                result_stall;
	logic [INDEX_W-1:0]  voice_index;
	logic [1:0]          action;
	logic [GAIN_W-1:0]   voice_gain;
	logic [POLE_W-1:0]   filter_pole;
	logic [MASK_W-1:0]   active_mask;
	logic [COUNT_W-1:0]  voices_sounding;

	int fail_count;
	int words_pending;
	int loads_seen;
	int steals_seen;
	int retrigs_seen;
	int ignored_seen;
	int ticks_seen;
	int reaps_seen;
	int hold_asked;
	int hold_served;
	int idle_cycles;

	drum_voice_allocator_unit dut (.*);

	dva_checker checker_i (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gap lengths: mostly short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one word after a gap and hold it until it is taken.
	task automatic send_word(input logic op, input logic [NOTE_W-1:0] nt,
			input logic [AMP_W-1:0] amp, input logic [MASK_W-1:0] fin, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid    <= 1'b1;
		opcode        <= op;
		note_number   <= nt;
		amplitude     <= amp;
		finished_mask <= fin;
		do @(posedge clk); while (item_stall);
	endtask

	// Random word: notes mostly from a small pool so that voices are
	// retriggered and stolen often.
	task automatic make_word(input int pool, output logic op, output logic [NOTE_W-1:0] nt,
			output logic [AMP_W-1:0] amp, output logic [MASK_W-1:0] fin);
		int r;
		op = ($urandom_range(0, 99) < 25) ? OPC_TICK : OPC_NOTE;
		if ($urandom_range(0, 3) != 0)
			nt = NOTE_W'(pool + $urandom_range(0, 5));
		else
			nt = NOTE_W'($urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if (r < 65) begin
			amp = AMP_W'($urandom_range(0, 32768));
		end else if (r < 75) begin
			amp = AMP_W'($urandom_range(32769, 65535));
		end else if (r < 85) begin
			amp = {1'b1, 16'($urandom)};
		end else if (r < 93) begin
			case ($urandom_range(0, 6))
				0: amp = 17'h00000;
				1: amp = 17'h07FFF;
				2: amp = 17'h08000;
				3: amp = 17'h08001;
				4: amp = 17'h0FFFF;
				5: amp = 17'h1FFFF;
				default: amp = 17'h10000;
			endcase
		end else begin
			amp = AMP_W'($urandom);
		end
		if ($urandom_range(0, 2) == 0)
			fin = MASK_W'(1 << $urandom_range(0, 3));
		else
			fin = MASK_W'($urandom);
	endtask

	// Receiver: random stalls in some stretches, none in others, and one
	// long hold-off when the sender asks for it.
	initial begin
		int  left;
		int  mode_left;
		bit  calm;
		logic stall;
		result_stall = 1'b0;
		left = 0;
		mode_left = 0;
		calm = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served < hold_asked) begin
				hold_served++;
				left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				calm = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (left > 0) begin
				stall = 1'b1;
				left--;
			end else if (!calm && $urandom_range(0, 99) < 30) begin
				stall = 1'b1;
				left = pick_gap() - 1;
			end else begin
				stall = 1'b0;
			end
			result_stall <= stall;
		end
	end

	// Watchdog: too long without any word moving ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles, %0d results outstanding",
					idle_cycles, words_pending);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		logic              op;
		logic [NOTE_W-1:0] nt;
		logic [AMP_W-1:0]  amp;
		logic [MASK_W-1:0] fin;
		int  sent;
		int  gap;
		int  calm_left;
		int  pool;
		bit  calm;
		bit  held;
		bit  drained;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		opcode        = OPC_NOTE;
		note_number   = '0;
		amplitude     = '0;
		finished_mask = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed opening: fill all voices, steal, retrigger sounding and
		// idle voices, clamp, ignore negative amplitudes, reap by mask.
		send_word(OPC_NOTE, 4'd0,  17'h00000, 4'hF, 0);
		send_word(OPC_NOTE, 4'd15, 17'h07FFF, 4'h0, 0);
		send_word(OPC_NOTE, 4'd3,  17'h08000, 4'hA, 0);
		send_word(OPC_NOTE, 4'd7,  17'h0FFFF, 4'h5, 0);
		send_word(OPC_NOTE, 4'd9,  17'h08001, 4'h0, 0);
		send_word(OPC_NOTE, 4'd15, 17'h00064, 4'hF, 0);
		send_word(OPC_NOTE, 4'd2,  17'h1FFFF, 4'h0, 0);
		send_word(OPC_NOTE, 4'd2,  17'h10000, 4'hF, 0);
		send_word(OPC_TICK, 4'd5,  17'h1ABCD, 4'h0, 0);
		send_word(OPC_TICK, 4'd0,  17'h00000, 4'h5, 0);
		send_word(OPC_NOTE, 4'd9,  17'h00005, 4'h0, 0);
		send_word(OPC_NOTE, 4'd15, 17'h003E8, 4'h0, 0);
		send_word(OPC_TICK, 4'd15, 17'h0FFFF, 4'hF, 0);
		send_word(OPC_NOTE, 4'd3,  17'h08000, 4'h0, 0);
		send_word(OPC_NOTE, 4'd4,  17'h00001, 4'hF, 0);
		send_word(OPC_TICK, 4'd9,  17'h1FFFF, 4'hF, 0);
		send_word(OPC_TICK, 4'd0,  17'h00000, 4'h0, 0);

		// Random part.
		sent = 0;
		calm_left = 0;
		calm = 1'b0;
		pool = 0;
		held = 1'b0;
		drained = 1'b0;
		while (sent < RANDOM_WORDS) begin
			if (calm_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				calm_left = $urandom_range(20, 120);
				pool = $urandom_range(0, 15);
			end
			calm_left--;
			make_word(pool, op, nt, amp, fin);
			gap = (calm || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
			send_word(op, nt, amp, fin, gap);
			sent++;
			// Long receiver hold-off while words keep coming.
			if (!held && sent >= 400) begin
				held = 1'b1;
				hold_asked++;
			end
			// Sender pause until every outstanding result is back.
			if (!drained && sent >= 900) begin
				drained = 1'b1;
				@(negedge clk);
				item_valid <= 1'b0;
				while (words_pending != 0) @(negedge clk);
			end
		end
		@(negedge clk);
		item_valid <= 1'b0;
		while (words_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d loads (%0d stealing the oldest voice), %0d retriggers, "
			, loads_seen, steals_seen, retrigs_seen);
		$display("%0d ignored note-ons and %0d sample ticks reaping %0d voices.",
			ignored_seen, ticks_seen, reaps_seen);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
